@@ design/servo_pose_interpolator_assert.svh @@
// ----------------------------------------------------------------------------
// servo pose interpolator assertion macros
// clocked checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SERVO_POSE_INTERPOLATOR_ASSERT_SVH
`define SERVO_POSE_INTERPOLATOR_ASSERT_SVH

// property that must hold at every clock edge
`define SPINT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked from the edge after the trigger
`define SPINT_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

@@ design/spint_pkg.sv @@
// ----------------------------------------------------------------------------
// spint_pkg
// types and constants of the servo pose interpolator
// ----------------------------------------------------------------------------
package spint_pkg;

  localparam int unsigned DivW      = 21;
  localparam logic [4:0]  DivCycles = 5'd21;
  localparam logic [7:0]  DegMax    = 8'd180;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DWELL,
    S_SETUP,
    S_DIV1,
    S_MAP,
    S_DIV2,
    S_STORE,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    CFG_HIP_MIN   = 3'd0,
    CFG_HIP_MAX   = 3'd1,
    CFG_KNEE_MIN  = 3'd2,
    CFG_KNEE_MAX  = 3'd3,
    CFG_ANKLE_MIN = 3'd4,
    CFG_ANKLE_MAX = 3'd5,
    CFG_PULSE_MIN = 3'd6,
    CFG_PULSE_MAX = 3'd7
  } cfg_idx_e;

endpackage

@@ design/servo_pose_interpolator.sv @@
// ----------------------------------------------------------------------------
// servo_pose_interpolator
// linear three-joint move interpolated into servo pulse counts
// ----------------------------------------------------------------------------
// A move request enters on the in channel (valid/ready) with start and end
// angles for hip, knee and ankle, a duration and a step count (zero means
// the default count). It yields one result request per step on the out
// channel: three pulse counts, the dwell time and a last-step flag.
// Limits and the pulse range are written through the cfg channel, which is
// always ready. All divisions go through one bit-serial restoring divider,
// one quotient bit per cycle. A move first divides the duration by the step
// count for the dwell time, then per step sets up and runs two divisions for
// each of the three joints in turn and emits the result.
// in_ready_o is high only while no move is in progress. A stalled receiver
// holds the result register and the sequencer waits before the next step.
// Reset clears the control state and loads the default limits.
// ----------------------------------------------------------------------------
module servo_pose_interpolator #(
  parameter int unsigned MAX_STEPS          = 64,
  parameter int unsigned DEFAULT_STEP_COUNT = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [9:0] hip_from_i,
  input  logic signed [9:0] hip_to_i,
  input  logic signed [9:0] knee_from_i,
  input  logic signed [9:0] knee_to_i,
  input  logic signed [9:0] ankle_from_i,
  input  logic signed [9:0] ankle_to_i,
  input  logic [15:0]       move_ms_i,
  input  logic [6:0]        step_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [11:0]       hip_pulse_o,
  output logic [11:0]       knee_pulse_o,
  output logic [11:0]       ankle_pulse_o,
  output logic [15:0]       dwell_ms_o,
  output logic              last_step_o
);

  localparam logic [6:0] MaxSteps = 7'(MAX_STEPS);
  localparam logic [6:0] DefSteps = 7'(DEFAULT_STEP_COUNT);

  spint_pkg::state_e state_q, state_d;

  logic [7:0]  lim_lo_q [3];
  logic [7:0]  lim_hi_q [3];
  logic [11:0] pmin_q, pmax_q;

  logic signed [9:0] from_q [3];
  logic signed [9:0] to_q   [3];
  logic [6:0]  n_q;
  logic [6:0]  step_q;
  logic [1:0]  joint_q;
  logic        neg_q;
  logic [15:0] dwell_q;
  logic [11:0] pulse_q [3];

  logic [spint_pkg::DivW-1:0] div_num_q;
  logic [7:0]  div_rem_q, div_den_q;
  logic [4:0]  div_cnt_q;

  logic        out_valid_q;
  logic [11:0] out_pulse_q [3];
  logic [15:0] out_dwell_q;
  logic        out_last_q;

  logic in_acc, emit_ok, is_last, div_busy;
  logic [6:0] n_in;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == spint_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign emit_ok     = !out_valid_q || out_ready_i;
  assign is_last     = (step_q == n_q);
  assign div_busy    = (div_cnt_q != 5'd0);

  always_comb begin
    if (step_count_i == 7'd0) begin
      n_in = DefSteps;
    end else if (step_count_i > MaxSteps) begin
      n_in = MaxSteps;
    end else begin
      n_in = step_count_i;
    end
  end

  // divider step
  logic [8:0] rem_sh;
  logic       div_ge;
  logic [8:0] rem_sub;
  assign rem_sh  = {div_rem_q, div_num_q[spint_pkg::DivW-1]};
  assign div_ge  = rem_sh >= {1'b0, div_den_q};
  assign rem_sub = rem_sh - {1'b0, div_den_q};

  // joint set-up: (to - from) * step
  logic signed [10:0] diff;
  logic signed [18:0] prod1;
  logic [18:0]        mag1;
  assign diff  = 11'(to_q[joint_q]) - 11'(from_q[joint_q]);
  assign prod1 = diff * $signed({1'b0, step_q});
  assign mag1  = prod1[18] ? 19'(-prod1) : 19'(prod1);

  // angle, clamp and pulse product
  logic [18:0]        q_mag;
  logic signed [18:0] q_s, a_s, a_c, lo_s, hi_s;
  logic [7:0]         angle;
  logic signed [12:0] span;
  logic signed [21:0] prod2;
  logic [21:0]        mag2;
  assign q_mag = {2'b00, div_num_q[16:0]};
  assign q_s   = neg_q ? $signed(19'd0 - q_mag - {18'd0, |div_rem_q}) : $signed(q_mag);
  assign a_s   = 19'(from_q[joint_q]) + q_s;
  assign lo_s  = $signed({11'd0, lim_lo_q[joint_q]});
  assign hi_s  = $signed({11'd0, lim_hi_q[joint_q]});

  always_comb begin
    if (a_s < lo_s) begin
      a_c = lo_s;
    end else if (a_s > hi_s) begin
      a_c = hi_s;
    end else begin
      a_c = a_s;
    end
    if (a_c < 19'sd0) begin
      angle = 8'd0;
    end else if (a_c > $signed({11'd0, spint_pkg::DegMax})) begin
      angle = spint_pkg::DegMax;
    end else begin
      angle = a_c[7:0];
    end
  end

  assign span  = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
  assign prod2 = $signed({1'b0, angle}) * span;
  assign mag2  = prod2[21] ? 22'(-prod2) : 22'(prod2);

  // pulse from the second quotient
  logic [11:0] q2, pulse_new;
  assign q2        = div_num_q[11:0];
  assign pulse_new = pmin_q + (neg_q ? (12'd0 - q2) : q2);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spint_pkg::S_IDLE:  if (in_acc) state_d = spint_pkg::S_DWELL;
      spint_pkg::S_DWELL: if (!div_busy) state_d = spint_pkg::S_SETUP;
      spint_pkg::S_SETUP: state_d = spint_pkg::S_DIV1;
      spint_pkg::S_DIV1:  if (!div_busy) state_d = spint_pkg::S_MAP;
      spint_pkg::S_MAP:   state_d = spint_pkg::S_DIV2;
      spint_pkg::S_DIV2:  if (!div_busy) state_d = spint_pkg::S_STORE;
      spint_pkg::S_STORE: begin
        state_d = (joint_q == 2'd2) ? spint_pkg::S_EMIT : spint_pkg::S_SETUP;
      end
      spint_pkg::S_EMIT: begin
        if (emit_ok) state_d = is_last ? spint_pkg::S_IDLE : spint_pkg::S_SETUP;
      end
      default: state_d = spint_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  logic div_load, do_emit, do_store, do_dwell;
  always_comb begin
    div_load = 1'b0;
    do_emit  = 1'b0;
    do_store = 1'b0;
    do_dwell = 1'b0;
    unique case (state_q)
      spint_pkg::S_IDLE:  div_load = in_acc;
      spint_pkg::S_DWELL: do_dwell = !div_busy;
      spint_pkg::S_SETUP: div_load = 1'b1;
      spint_pkg::S_MAP:   div_load = 1'b1;
      spint_pkg::S_STORE: do_store = 1'b1;
      spint_pkg::S_EMIT:  do_emit  = emit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spint_pkg::S_IDLE;
      lim_lo_q[0] <= 8'd0;
      lim_hi_q[0] <= 8'd180;
      lim_lo_q[1] <= 8'd0;
      lim_hi_q[1] <= 8'd90;
      lim_lo_q[2] <= 8'd0;
      lim_hi_q[2] <= 8'd180;
      pmin_q      <= 12'd150;
      pmax_q      <= 12'd600;
      step_q      <= 7'd0;
      joint_q     <= 2'd0;
      div_cnt_q   <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          spint_pkg::CFG_HIP_MIN:   lim_lo_q[0] <= cfg_data_i[7:0];
          spint_pkg::CFG_HIP_MAX:   lim_hi_q[0] <= cfg_data_i[7:0];
          spint_pkg::CFG_KNEE_MIN:  lim_lo_q[1] <= cfg_data_i[7:0];
          spint_pkg::CFG_KNEE_MAX:  lim_hi_q[1] <= cfg_data_i[7:0];
          spint_pkg::CFG_ANKLE_MIN: lim_lo_q[2] <= cfg_data_i[7:0];
          spint_pkg::CFG_ANKLE_MAX: lim_hi_q[2] <= cfg_data_i[7:0];
          spint_pkg::CFG_PULSE_MIN: pmin_q      <= cfg_data_i;
          spint_pkg::CFG_PULSE_MAX: pmax_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        step_q  <= 7'd1;
        joint_q <= 2'd0;
      end
      if (do_store) begin
        joint_q <= (joint_q == 2'd2) ? 2'd0 : joint_q + 2'd1;
      end
      if (do_emit && !is_last) begin
        step_q <= step_q + 7'd1;
      end
      if (div_load) begin
        div_cnt_q <= spint_pkg::DivCycles;
      end else if (div_busy) begin
        div_cnt_q <= div_cnt_q - 5'd1;
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      from_q[0] <= hip_from_i;
      to_q[0]   <= hip_to_i;
      from_q[1] <= knee_from_i;
      to_q[1]   <= knee_to_i;
      from_q[2] <= ankle_from_i;
      to_q[2]   <= ankle_to_i;
      n_q       <= n_in;
    end
    if (div_load) begin
      div_rem_q <= 8'd0;
      unique case (state_q)
        spint_pkg::S_IDLE: begin
          div_num_q <= {5'd0, move_ms_i};
          div_den_q <= {1'b0, n_in};
        end
        spint_pkg::S_SETUP: begin
          div_num_q <= {2'b00, mag1};
          div_den_q <= {1'b0, n_q};
          neg_q     <= prod1[18];
        end
        default: begin
          div_num_q <= mag2[spint_pkg::DivW-1:0];
          div_den_q <= spint_pkg::DegMax;
          neg_q     <= prod2[21];
        end
      endcase
    end else if (div_busy) begin
      div_rem_q <= div_ge ? rem_sub[7:0] : rem_sh[7:0];
      div_num_q <= {div_num_q[spint_pkg::DivW-2:0], div_ge};
    end
    if (do_dwell) begin
      dwell_q <= div_num_q[15:0];
    end
    if (do_store) begin
      pulse_q[joint_q] <= pulse_new;
    end
    if (do_emit) begin
      out_pulse_q <= pulse_q;
      out_dwell_q <= dwell_q;
      out_last_q  <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hip_pulse_o   = out_pulse_q[0];
  assign knee_pulse_o  = out_pulse_q[1];
  assign ankle_pulse_o = out_pulse_q[2];
  assign dwell_ms_o    = out_dwell_q;
  assign last_step_o   = out_last_q;

  `include "servo_pose_interpolator_assert.svh"

  `SPINT_ASSERT(a_div_done_map, (state_q != spint_pkg::S_MAP) || !div_busy,
                "map before division done")
  `SPINT_ASSERT(a_step_range,
                (state_q == spint_pkg::S_IDLE) || ((step_q != 7'd0) && (step_q <= n_q)),
                "step index out of range")
  `SPINT_ASSERT_NEXT(a_last_idle, (state_q == spint_pkg::S_EMIT) && emit_ok && is_last,
                     state_q == spint_pkg::S_IDLE, "no idle after last step")
  `SPINT_ASSERT_NEXT(a_emit_valid, do_emit, out_valid_q, "emitted result not valid")

endmodule

@@ verif/servo_pose_interpolator_checker.sv @@
// ----------------------------------------------------------------------------
// servo pose interpolator checker
// watches the move and config channels, predicts the per-step pulse results
// and compares every accepted result against the oldest prediction
// ----------------------------------------------------------------------------
module servo_pose_interpolator_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic signed [9:0] hip_from_i,
  input  logic signed [9:0] hip_to_i,
  input  logic signed [9:0] knee_from_i,
  input  logic signed [9:0] knee_to_i,
  input  logic signed [9:0] ankle_from_i,
  input  logic signed [9:0] ankle_to_i,
  input  logic [15:0]       move_ms_i,
  input  logic [6:0]        step_count_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [11:0]       hip_pulse_i,
  input  logic [11:0]       knee_pulse_i,
  input  logic [11:0]       ankle_pulse_i,
  input  logic [15:0]       dwell_ms_i,
  input  logic              last_step_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                steps_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] hip;
    logic [11:0] knee;
    logic [11:0] ankle;
    logic [15:0] dwell;
    logic        last;
  } step_t;

  step_t pose_q[$];
  logic [7:0]  lim_lo[3];
  logic [7:0]  lim_hi[3];
  logic [11:0] pmin, pmax;

  function automatic int floor_div(int num, int den);
    int q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [11:0] joint_pulse(int from, int to, int i, int n, int j);
    int a;
    int span;
    int p;
    a = from + floor_div((to - from) * i, n);
    if (a < int'(lim_lo[j])) a = lim_lo[j];
    else if (a > int'(lim_hi[j])) a = lim_hi[j];
    if (a < 0) a = 0;
    if (a > 180) a = 180;
    span = int'(pmax) - int'(pmin);
    p = int'(pmin) + (a * span) / 180;
    return p[11:0];
  endfunction

  task automatic predict_move();
    int n;
    step_t s;
    n = step_count_i;
    if (n == 0) n = 20;
    if (n > 64) n = 64;
    for (int i = 1; i <= n; i++) begin
      s.hip   = joint_pulse(hip_from_i, hip_to_i, i, n, 0);
      s.knee  = joint_pulse(knee_from_i, knee_to_i, i, n, 1);
      s.ankle = joint_pulse(ankle_from_i, ankle_to_i, i, n, 2);
      s.dwell = 16'(int'(move_ms_i) / n);
      s.last  = (i == n);
      pose_q.push_back(s);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_t e;
    if (!rst_ni) begin
      lim_lo = '{8'd0, 8'd0, 8'd0};
      lim_hi = '{8'd180, 8'd90, 8'd180};
      pmin = 12'd150;
      pmax = 12'd600;
      pose_q.delete();
      fail_count_o <= 0;
      steps_seen_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (spint_pkg::cfg_idx_e'(cfg_index_i))
          spint_pkg::CFG_HIP_MIN:   lim_lo[0] = cfg_data_i[7:0];
          spint_pkg::CFG_HIP_MAX:   lim_hi[0] = cfg_data_i[7:0];
          spint_pkg::CFG_KNEE_MIN:  lim_lo[1] = cfg_data_i[7:0];
          spint_pkg::CFG_KNEE_MAX:  lim_hi[1] = cfg_data_i[7:0];
          spint_pkg::CFG_ANKLE_MIN: lim_lo[2] = cfg_data_i[7:0];
          spint_pkg::CFG_ANKLE_MAX: lim_hi[2] = cfg_data_i[7:0];
          spint_pkg::CFG_PULSE_MIN: pmin = cfg_data_i;
          spint_pkg::CFG_PULSE_MAX: pmax = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        steps_seen_o <= steps_seen_o + 1;
        if (pose_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("ERROR: unexpected step result h%0d k%0d a%0d d%0d l%0d",
                     hip_pulse_i, knee_pulse_i, ankle_pulse_i, dwell_ms_i, last_step_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = pose_q.pop_front();
          if (e != {hip_pulse_i, knee_pulse_i, ankle_pulse_i, dwell_ms_i, last_step_i}) begin
            if (fail_count_o < 10)
              $display({"ERROR: step mismatch exp h%0d k%0d a%0d d%0d l%0d",
                        " got h%0d k%0d a%0d d%0d l%0d"},
                       e.hip, e.knee, e.ankle, e.dwell, e.last, hip_pulse_i, knee_pulse_i,
                       ankle_pulse_i, dwell_ms_i, last_step_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_move();
      pending_o <= pose_q.size();
    end
  end

endmodule

@@ verif/servo_pose_interpolator_tb.sv @@
// ----------------------------------------------------------------------------
// servo pose interpolator testbench
// directed and random move requests over several limit and pulse settings,
// random idling on both channels, results checked by the checker module
// ----------------------------------------------------------------------------
module servo_pose_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [11:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [9:0] hip_from, hip_to, knee_from, knee_to, ankle_from, ankle_to;
  logic [15:0] move_ms;
  logic [6:0] step_count;
  logic out_valid, out_ready;
  logic [11:0] hip_pulse, knee_pulse, ankle_pulse;
  logic [15:0] dwell_ms;
  logic last_step;
  int fail_count, pending, steps_seen;
  int idle_cycles;
  int moves_sent;
  bit quiet;

  servo_pose_interpolator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .hip_from_i(hip_from), .hip_to_i(hip_to),
    .knee_from_i(knee_from), .knee_to_i(knee_to),
    .ankle_from_i(ankle_from), .ankle_to_i(ankle_to),
    .move_ms_i(move_ms), .step_count_i(step_count),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hip_pulse_o(hip_pulse), .knee_pulse_o(knee_pulse), .ankle_pulse_o(ankle_pulse),
    .dwell_ms_o(dwell_ms), .last_step_o(last_step)
  );

  servo_pose_interpolator_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .hip_from_i(hip_from), .hip_to_i(hip_to),
    .knee_from_i(knee_from), .knee_to_i(knee_to),
    .ankle_from_i(ankle_from), .ankle_to_i(ankle_to),
    .move_ms_i(move_ms), .step_count_i(step_count),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .hip_pulse_i(hip_pulse), .knee_pulse_i(knee_pulse), .ankle_pulse_i(ankle_pulse),
    .dwell_ms_i(dwell_ms), .last_step_i(last_step),
    .fail_count_o(fail_count), .pending_o(pending), .steps_seen_o(steps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stalls in random bursts while not quiet
  initial begin
    int gap;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(spint_pkg::cfg_idx_e idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_move(logic [9:0] hf, logic [9:0] ht, logic [9:0] kf, logic [9:0] kt,
                           logic [9:0] af, logic [9:0] at, logic [15:0] ms, logic [6:0] n);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    hip_from <= hf; hip_to <= ht;
    knee_from <= kf; knee_to <= kt;
    ankle_from <= af; ankle_to <= at;
    move_ms <= ms; step_count <= n;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    moves_sent++;
    @(posedge clk);
  endtask

  function automatic logic [9:0] rnd_angle();
    if ($urandom_range(0, 9) == 0) return 10'($urandom);
    return 10'($urandom_range(0, 540) - 180);
  endfunction

  function automatic logic [6:0] rnd_steps();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'($urandom_range(65, 127));
    if (r == 2) return 7'd64;
    return 7'($urandom_range(1, 6));
  endfunction

  task automatic random_moves(int count);
    for (int k = 0; k < count; k++)
      send_move(rnd_angle(), rnd_angle(), rnd_angle(), rnd_angle(), rnd_angle(), rnd_angle(),
                16'($urandom), rnd_steps());
  endtask

  task automatic random_limits();
    for (int r = 0; r < 8; r++) begin
      if (r < 6) write_reg(spint_pkg::cfg_idx_e'(r), 12'($urandom_range(0, 255)));
      else write_reg(spint_pkg::cfg_idx_e'(r), 12'($urandom));
    end
  endtask

  initial begin
    quiet = 1'b0;
    moves_sent = 0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    hip_from = '0; hip_to = '0; knee_from = '0; knee_to = '0;
    ankle_from = '0; ankle_to = '0; move_ms = '0; step_count = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed moves at reset limits
    send_move(10'h000, 10'd180, 10'h000, 10'd90, 10'd180, 10'h000, 16'd1000, 7'd0);
    send_move(10'h200, 10'h1FF, 10'h1FF, 10'h200, 10'h3FF, 10'h001, 16'hFFFF, 7'd1);
    send_move(-10'sd180, 10'd360, 10'd360, -10'sd180, 10'd45, 10'd45, 16'd0, 7'd64);
    send_move(10'd10, 10'd3, -10'sd7, 10'd5, 10'd0, -10'sd1, 16'd7, 7'd127);
    send_move(10'h155, 10'h2AA, 10'h2AA, 10'h155, 10'd100, 10'd20, 16'h5555, 7'h55);
    send_move(10'd0, 10'd1, 10'd0, 10'd0, 10'd180, 10'd181, 16'hAAAA, 7'h2A);
    drain();

    // lower limit above upper, limits above 180, downward pulse map
    write_reg(spint_pkg::CFG_HIP_MIN, 12'd120);
    write_reg(spint_pkg::CFG_HIP_MAX, 12'd60);
    write_reg(spint_pkg::CFG_KNEE_MIN, 12'd200);
    write_reg(spint_pkg::CFG_KNEE_MAX, 12'd255);
    write_reg(spint_pkg::CFG_ANKLE_MIN, 12'd0);
    write_reg(spint_pkg::CFG_ANKLE_MAX, 12'd255);
    write_reg(spint_pkg::CFG_PULSE_MIN, 12'd4095);
    write_reg(spint_pkg::CFG_PULSE_MAX, 12'd0);
    send_move(10'd0, 10'd180, 10'd0, 10'd180, -10'sd180, 10'd360, 16'd500, 7'd9);
    send_move(10'd90, 10'd90, 10'd190, 10'd10, 10'd360, -10'sd180, 16'd3, 7'd5);
    drain();

    write_reg(spint_pkg::CFG_HIP_MIN, 12'd0);
    write_reg(spint_pkg::CFG_HIP_MAX, 12'd0);
    write_reg(spint_pkg::CFG_KNEE_MIN, 12'd180);
    write_reg(spint_pkg::CFG_KNEE_MAX, 12'd180);
    write_reg(spint_pkg::CFG_PULSE_MIN, 12'd0);
    write_reg(spint_pkg::CFG_PULSE_MAX, 12'd4095);
    send_move(10'd50, 10'd150, 10'd50, 10'd150, 10'd0, 10'd180, 16'd99, 7'd4);
    drain();

    // random phases, each under its own setting
    for (int ph = 0; ph < 4; ph++) begin
      random_limits();
      random_moves(50);
      drain();
    end
    write_reg(spint_pkg::CFG_HIP_MIN, 12'd0);
    write_reg(spint_pkg::CFG_HIP_MAX, 12'd180);
    write_reg(spint_pkg::CFG_KNEE_MIN, 12'd0);
    write_reg(spint_pkg::CFG_KNEE_MAX, 12'd180);
    write_reg(spint_pkg::CFG_ANKLE_MIN, 12'd0);
    write_reg(spint_pkg::CFG_ANKLE_MAX, 12'd180);
    write_reg(spint_pkg::CFG_PULSE_MIN, 12'd150);
    write_reg(spint_pkg::CFG_PULSE_MAX, 12'd600);
    random_moves(30);

    // closing stretch with no idling
    quiet = 1'b1;
    random_moves(30);
    drain();

    $display("covered %0d move requests and %0d step results over eight limit settings",
             moves_sent, steps_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/spint_pkg.sv
design/servo_pose_interpolator.sv
verif/servo_pose_interpolator_checker.sv
verif/servo_pose_interpolator_tb.sv
